// ===== design/gdd_pkg.sv =====
// Package for the Gregorian date difference block.
// Holds shared constants, lane interface structs and the calendar table functions.
// No dependencies.
package gdd_pkg;

  localparam int unsigned FirstYear = 1900;
  localparam int unsigned LastYear  = 3000;
  localparam int unsigned DaysPerYear = 365;

  // Leap years in 1..1899, the base subtracted from every day number.
  localparam int unsigned LeapBase = 1899 / 4 - 1899 / 100 + 1899 / 400;

  // floor(x / 100) == (x * Recip100) >> Recip100Shift for every 12-bit x.
  localparam int unsigned Recip100      = 5243;
  localparam int unsigned Recip100Shift = 19;

  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DnumW  = 20;
  localparam int unsigned WdayW  = 3;

  typedef struct packed {
    logic en1;
    logic en2;
  } lane_ctrl_t;

  typedef struct packed {
    logic             ok;
    logic [DnumW-1:0] dnum;
  } lane_res_t;

  // Days before the first of the month in a common year.
  function automatic logic [8:0] month_start(input logic [MonthW-1:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of the month in a common year; zero for a month code that means nothing.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/gdd_lane.sv =====
// One date lane: validity check and conversion to days since 1 January 1900.
// Two register stages; depends on gdd_pkg.
module gdd_lane (
  input  logic                         clk,
  input  gdd_pkg::lane_ctrl_t          ctrl,
  input  logic [gdd_pkg::DayW-1:0]     day,
  input  logic [gdd_pkg::MonthW-1:0]   month,
  input  logic [gdd_pkg::YearW-1:0]    year,
  output gdd_pkg::lane_res_t           res
);

  logic                        year_ok;
  logic                        month_ok;
  logic                        century;
  logic                        leap;
  logic [gdd_pkg::DayW-1:0]    len;
  logic                        date_ok;
  logic [gdd_pkg::YearW-1:0]   ym1;
  logic [gdd_pkg::YearW-1:0]   yoff;
  logic [24:0]                 prod100;
  logic [gdd_pkg::DnumW-1:0]   y365;
  logic [8:0]                  ms_adj;

  logic                        s1_ok;
  logic [gdd_pkg::DnumW-1:0]   s1_y365;
  logic [9:0]                  s1_q4;
  logic [5:0]                  s1_q100;
  logic [8:0]                  s1_ms;
  logic [gdd_pkg::DayW-1:0]    s1_day;
  logic [gdd_pkg::DnumW-1:0]   dnum_next;
  logic                        s2_ok;
  logic [gdd_pkg::DnumW-1:0]   s2_dnum;

  always_comb begin
    year_ok  = (year >= 12'(gdd_pkg::FirstYear)) && (year <= 12'(gdd_pkg::LastYear));
    month_ok = (month >= 4'd1) && (month <= 4'd12);
    // Within the valid range the centuries are 1900..3000; only 2000, 2400, 2800 are leap.
    century = 1'b0;
    for (int k = 19; k <= 30; k++) begin
      if (year == 12'(k * 100)) century = 1'b1;
    end
    leap = (year[1:0] == 2'b00) &&
           (!century || year == 12'd2000 || year == 12'd2400 || year == 12'd2800);
    len = gdd_pkg::month_len(month);
    if (month == 4'd2 && leap) len = 5'd29;
    date_ok = year_ok && month_ok && (day >= 5'd1) && (day <= len);

    ym1     = year - 12'd1;
    yoff    = year - 12'(gdd_pkg::FirstYear);
    prod100 = 25'(ym1) * 25'(gdd_pkg::Recip100);
    // 365 = 256 + 64 + 32 + 8 + 4 + 1
    y365 = (20'(yoff) << 8) + (20'(yoff) << 6) + (20'(yoff) << 5) +
           (20'(yoff) << 3) + (20'(yoff) << 2) + 20'(yoff);
    ms_adj = gdd_pkg::month_start(month) + 9'((month > 4'd2) && leap);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      s1_ok   <= date_ok;
      s1_y365 <= y365;
      s1_q4   <= ym1[11:2];
      s1_q100 <= prod100[gdd_pkg::Recip100Shift +: 6];
      s1_ms   <= ms_adj;
      s1_day  <= day;
    end
  end

  // Leap count uses y/400 == (y/100)/4.
  assign dnum_next = s1_y365 + 20'(s1_q4) - 20'(s1_q100) + 20'(s1_q100[5:2]) +
                     20'(s1_ms) + 20'(s1_day) - 20'(gdd_pkg::LeapBase + 1);

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      s2_ok   <= s1_ok;
      s2_dnum <= dnum_next;
    end
  end

  assign res.ok   = s2_ok;
  assign res.dnum = s2_dnum;

endmodule

// ===== design/gdd_merge.sv =====
// Merge stage: difference of the two lane day numbers and weekday of the end date.
// Drives the registered result payload; depends on gdd_pkg.
module gdd_merge (
  input  logic                              clk,
  input  logic                              en,
  input  gdd_pkg::lane_res_t                from_res,
  input  gdd_pkg::lane_res_t                to_res,
  output logic signed [gdd_pkg::DnumW-1:0]  day_difference,
  output logic                              from_valid,
  output logic                              to_valid,
  output logic [gdd_pkg::WdayW-1:0]         to_weekday
);

  logic                       both_ok;
  logic [gdd_pkg::DnumW-1:0]  diff;
  logic [gdd_pkg::DnumW-1:0]  x;
  logic [5:0]                 osum;
  logic [3:0]                 fold1;
  logic [3:0]                 fold2;
  logic [gdd_pkg::WdayW-1:0]  wday;

  always_comb begin
    both_ok = from_res.ok && to_res.ok;
    diff    = to_res.dnum - from_res.dnum;
    x       = to_res.dnum + 20'd1;
    // Since 8 is 1 mod 7, the sum of the octal digits keeps the residue.
    osum = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) +
           6'(x[14:12]) + 6'(x[17:15]) + 6'(x[19:18]);
    fold1 = 4'(osum[5:3]) + 4'(osum[2:0]);
    fold2 = 4'(fold1[3]) + 4'(fold1[2:0]);
    wday  = (fold2 == 4'd7) ? 3'd0 : fold2[2:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_difference <= both_ok ? diff : '0;
      to_weekday     <= both_ok ? wday : '0;
      from_valid     <= from_res.ok;
      to_valid       <= to_res.ok;
    end
  end

endmodule

// ===== design/gregorian_date_difference_top.sv =====
// Top level of the Gregorian date difference block.
// Instantiates two gdd_lane copies and gdd_merge; depends on gdd_pkg.
//
// Each request carries two dates (day, month, year). The block reports whether
// each date is valid (year 1900 to 3000, month 1 to 12, day within the month,
// with the full Gregorian leap rule), the signed number of days from the start
// date to the end date, and the weekday of the end date (0 is Sunday). When
// either date is invalid the difference and weekday are zero. A new request is
// accepted every clock cycle while in_stall is low. An accepted request passes
// through three register stages in order: two inside each date lane (calendar
// decode with a reciprocal multiply for the century count, then the day-number
// sum) and one in the merge stage that subtracts the day numbers, reduces the
// end date mod 7 and holds the result on the outputs until out_stall is low.
// Each stage advances whenever its successor is empty or advancing, so empty
// slots are filled even while a finished result waits on a stalled output, and
// in_stall rises only when all three stages hold requests and the output is
// stalled.
module gregorian_date_difference_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [gdd_pkg::DayW-1:0]          from_day,
  input  logic [gdd_pkg::MonthW-1:0]        from_month,
  input  logic [gdd_pkg::YearW-1:0]         from_year,
  input  logic [gdd_pkg::DayW-1:0]          to_day,
  input  logic [gdd_pkg::MonthW-1:0]        to_month,
  input  logic [gdd_pkg::YearW-1:0]         to_year,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [gdd_pkg::DnumW-1:0]  day_difference,
  output logic                              from_valid,
  output logic                              to_valid,
  output logic [gdd_pkg::WdayW-1:0]         to_weekday
);

  // Occupancy of the two lane stages; out_valid covers the merge stage.
  logic v1;
  logic v2;
  logic en1;
  logic en2;
  logic en3;

  gdd_pkg::lane_ctrl_t ctrl;
  gdd_pkg::lane_res_t  from_res;
  gdd_pkg::lane_res_t  to_res;

  // A stage loads when it is empty or its contents move on this cycle.
  assign en3 = !out_valid || !out_stall;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall = !en1;

  assign ctrl.en1 = en1;
  assign ctrl.en2 = en2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) out_valid <= v2;
    end
  end

  // Both lanes share the enables, so the two dates of a request stay paired.
  gdd_lane u_from_lane (
    .clk   (clk),
    .ctrl  (ctrl),
    .day   (from_day),
    .month (from_month),
    .year  (from_year),
    .res   (from_res)
  );

  gdd_lane u_to_lane (
    .clk   (clk),
    .ctrl  (ctrl),
    .day   (to_day),
    .month (to_month),
    .year  (to_year),
    .res   (to_res)
  );

  gdd_merge u_merge (
    .clk            (clk),
    .en             (en3),
    .from_res       (from_res),
    .to_res         (to_res),
    .day_difference (day_difference),
    .from_valid     (from_valid),
    .to_valid       (to_valid),
    .to_weekday     (to_weekday)
  );

`ifndef SYNTH
  // The input is held off only when every stage is full and the output is stalled.
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && out_valid && out_stall))
    else $error("in_stall raised with a free pipeline slot");

  // An invalid date forces a zero difference and weekday.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !(from_valid && to_valid)) |-> (day_difference == '0 && to_weekday == '0))
    else $error("nonzero result for an invalid date");

  // The mod 7 reduction never yields seven.
  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (to_weekday != 3'd7))
    else $error("weekday out of range");

  // A request in the last lane stage reaches the output when the output is free.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (v2 && en3) |=> out_valid)
    else $error("request lost between lane and merge stage");
`endif

endmodule

// ===== verif/gdd_span_checker.sv =====
// Checker for the Gregorian date difference block: watches both channels,
// predicts each result from its request and compares it with what comes out.
// Depends on gdd_pkg for widths and the calendar year limits.
module gdd_span_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [gdd_pkg::DayW-1:0]          from_day,
  input  logic [gdd_pkg::MonthW-1:0]        from_month,
  input  logic [gdd_pkg::YearW-1:0]         from_year,
  input  logic [gdd_pkg::DayW-1:0]          to_day,
  input  logic [gdd_pkg::MonthW-1:0]        to_month,
  input  logic [gdd_pkg::YearW-1:0]         to_year,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [gdd_pkg::DnumW-1:0]  day_difference,
  input  logic                              from_valid,
  input  logic                              to_valid,
  input  logic [gdd_pkg::WdayW-1:0]         to_weekday,
  output int                                mismatch_count,
  output int                                pending_count
);

  typedef struct packed {
    logic [gdd_pkg::DnumW-1:0] diff;
    logic                      from_ok;
    logic                      to_ok;
    logic [gdd_pkg::WdayW-1:0] weekday;
  } date_span_t;

  date_span_t spans_due[$];

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic bit date_in_range(int unsigned d, int unsigned m, int unsigned y);
    if (y < gdd_pkg::FirstYear || y > gdd_pkg::LastYear || m < 1 || m > 12) return 1'b0;
    return d >= 1 && d <= days_in_month(m, y);
  endfunction

  function automatic int unsigned leaps_through(int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  // Days since 1 January 1900; only meaningful for a date in range.
  function automatic int days_from_epoch(int unsigned d, int unsigned m, int unsigned y);
    int unsigned n;
    n = gdd_pkg::DaysPerYear * (y - gdd_pkg::FirstYear) + leaps_through(y - 1) -
        leaps_through(gdd_pkg::FirstYear - 1);
    for (int unsigned mi = 1; mi < m; mi++) n += days_in_month(mi, y);
    return int'(n + d - 1);
  endfunction

  function automatic date_span_t predict_span(
    int unsigned fd, int unsigned fm, int unsigned fy,
    int unsigned td, int unsigned tm, int unsigned ty
  );
    date_span_t s;
    int a;
    int b;
    s = '0;
    s.from_ok = date_in_range(fd, fm, fy);
    s.to_ok   = date_in_range(td, tm, ty);
    if (s.from_ok && s.to_ok) begin
      a = days_from_epoch(fd, fm, fy);
      b = days_from_epoch(td, tm, ty);
      s.diff    = gdd_pkg::DnumW'(b - a);
      // Day zero was a Monday, and Sunday counts as zero.
      s.weekday = gdd_pkg::WdayW'((b + 1) % 7);
    end
    return s;
  endfunction

  always @(posedge clk) begin
    date_span_t want;
    if (rst) begin
      spans_due.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (spans_due.size() == 0) begin
          $error("result with no request outstanding: day_difference %0d", day_difference);
          mismatch_count++;
        end else begin
          want = spans_due.pop_front();
          if (day_difference !== want.diff) begin
            $error("day_difference: expected %0d, got %0d", $signed(want.diff),
                   day_difference);
            mismatch_count++;
          end
          if (from_valid !== want.from_ok) begin
            $error("from_valid: expected %0b, got %0b", want.from_ok, from_valid);
            mismatch_count++;
          end
          if (to_valid !== want.to_ok) begin
            $error("to_valid: expected %0b, got %0b", want.to_ok, to_valid);
            mismatch_count++;
          end
          if (to_weekday !== want.weekday) begin
            $error("to_weekday: expected %0d, got %0d", want.weekday, to_weekday);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        spans_due.push_back(predict_span(from_day, from_month, from_year,
                                         to_day, to_month, to_year));
      end
    end
    pending_count = spans_due.size();
  end

endmodule

// ===== verif/tb_gregorian_date_difference_top.sv =====
// Testbench top for the Gregorian date difference block: drives requests and
// output stalls, runs the watchdog and prints the verdict.
// Depends on gdd_pkg, gregorian_date_difference_top and gdd_span_checker.
module tb_gregorian_date_difference_top;

  // Random requests after the directed ones.
  localparam int RandomRequests = 1150;
  // Cycles without any handshake before the run is declared hung. The worst
  // legal stretch is a long random output stall, which stays far below this.
  localparam int IdleLimit = 1000;
  // Cycles allowed after the last result for stray outputs to show up; the
  // pipeline is three stages deep.
  localparam int DrainCycles = 12;

  logic                              clk        = 1'b0;
  logic                              rst        = 1'b1;
  logic                              in_valid   = 1'b0;
  logic                              in_stall;
  logic [gdd_pkg::DayW-1:0]          from_day   = '0;
  logic [gdd_pkg::MonthW-1:0]        from_month = '0;
  logic [gdd_pkg::YearW-1:0]         from_year  = '0;
  logic [gdd_pkg::DayW-1:0]          to_day     = '0;
  logic [gdd_pkg::MonthW-1:0]        to_month   = '0;
  logic [gdd_pkg::YearW-1:0]         to_year    = '0;
  logic                              out_valid;
  logic                              out_stall  = 1'b0;
  logic signed [gdd_pkg::DnumW-1:0]  day_difference;
  logic                              from_valid;
  logic                              to_valid;
  logic [gdd_pkg::WdayW-1:0]         to_weekday;

  int                                mismatch_count;
  int                                pending_count;
  int                                idle_cycles = 0;
  logic [9:0]                        stall_tick  = '0;

  always #6 clk = ~clk;

  gregorian_date_difference_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .from_day       (from_day),
    .from_month     (from_month),
    .from_year      (from_year),
    .to_day         (to_day),
    .to_month       (to_month),
    .to_year        (to_year),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .day_difference (day_difference),
    .from_valid     (from_valid),
    .to_valid       (to_valid),
    .to_weekday     (to_weekday)
  );

  // The checker sees the same wires as the block and keeps the expected
  // results; the top only reads back how many failed and how many are due.
  gdd_span_checker i_span_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .from_day       (from_day),
    .from_month     (from_month),
    .from_year      (from_year),
    .to_day         (to_day),
    .to_month       (to_month),
    .to_year        (to_year),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .day_difference (day_difference),
    .from_valid     (from_valid),
    .to_valid       (to_valid),
    .to_weekday     (to_weekday),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // The output side stalls on its own schedule, independent of the sender.
  // Each step of its top tick bits brings the next mode: no stalls at all, light
  // random stalls, heavy random stalls, then a fixed pattern that stalls while
  // the low tick bits are below eleven. The heavy modes fill the pipeline and
  // push back on the input side, while the quiet mode lets results stream out.
  always @(negedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_tick <= '0;
    end else begin
      stall_tick <= stall_tick + 1'b1;
      case (stall_tick[9:8])
        2'd0:    out_stall <= 1'b0;
        2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
        2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_tick[3:0] < 4'd11);
      endcase
    end
  end

  // Watchdog: any cycle with a handshake on either channel restarts the count.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one request at a falling edge and holds it until the block takes
  // it at a rising edge. A nonzero gap first holds valid low for the gap.
  // The task returns on the falling edge after acceptance, so the caller's next
  // assignment to valid lands in a later time step than the one made here.
  task automatic send_dates(
    input int                         gap,
    input logic [gdd_pkg::DayW-1:0]   fd,
    input logic [gdd_pkg::MonthW-1:0] fm,
    input logic [gdd_pkg::YearW-1:0]  fy,
    input logic [gdd_pkg::DayW-1:0]   td,
    input logic [gdd_pkg::MonthW-1:0] tm,
    input logic [gdd_pkg::YearW-1:0]  ty
  );
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    from_day   <= fd;
    from_month <= fm;
    from_year  <= fy;
    to_day     <= td;
    to_month   <= tm;
    to_year    <= ty;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stops sending until every outstanding request has produced its result.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  // A date with a year in range and a month in 1..12. The day is usually one
  // that every month has; one time in five it sits at the end of a month, so
  // February 29 and the 31st of short months come up, both valid and not.
  // Century years and the two boundary years get extra weight.
  task automatic pick_date(
    output logic [gdd_pkg::DayW-1:0]   d,
    output logic [gdd_pkg::MonthW-1:0] m,
    output logic [gdd_pkg::YearW-1:0]  y
  );
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      y = gdd_pkg::YearW'(gdd_pkg::FirstYear + 100 * $urandom_range(0, 11));
    end else if (pick < 12) begin
      y = gdd_pkg::YearW'(gdd_pkg::FirstYear);
    end else if (pick < 14) begin
      y = gdd_pkg::YearW'(gdd_pkg::LastYear);
    end else begin
      y = gdd_pkg::YearW'($urandom_range(gdd_pkg::FirstYear, gdd_pkg::LastYear));
    end
    m = gdd_pkg::MonthW'($urandom_range(1, 12));
    if ($urandom_range(0, 4) == 0) d = gdd_pkg::DayW'($urandom_range(28, 31));
    else                           d = gdd_pkg::DayW'($urandom_range(1, 28));
  endtask

  // Alters one field of a date: day zero or a day in 29..31 (past the end only of
  // a short month), a month code outside 1..12, or a year outside 1900..3000.
  task automatic break_date(
    inout logic [gdd_pkg::DayW-1:0]   d,
    inout logic [gdd_pkg::MonthW-1:0] m,
    inout logic [gdd_pkg::YearW-1:0]  y
  );
    case ($urandom_range(0, 2))
      0: d = $urandom_range(0, 1) ? gdd_pkg::DayW'(0) :
                                    gdd_pkg::DayW'($urandom_range(29, 31));
      1: m = $urandom_range(0, 1) ? gdd_pkg::MonthW'(0) :
                                    gdd_pkg::MonthW'($urandom_range(13, 15));
      default: begin
        if ($urandom_range(0, 1)) begin
          y = gdd_pkg::YearW'($urandom_range(0, gdd_pkg::FirstYear - 1));
        end else begin
          y = gdd_pkg::YearW'($urandom_range(gdd_pkg::LastYear + 1, 4095));
        end
      end
    endcase
  endtask

  initial begin
    logic [gdd_pkg::DayW-1:0]   fd;
    logic [gdd_pkg::MonthW-1:0] fm;
    logic [gdd_pkg::YearW-1:0]  fy;
    logic [gdd_pkg::DayW-1:0]   td;
    logic [gdd_pkg::MonthW-1:0] tm;
    logic [gdd_pkg::YearW-1:0]  ty;
    logic [63:0]                noise;
    int                         burst_left;
    int                         gap;
    int unsigned                kind;

    burst_left = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests, back to back.
    // The same date on both sides, at the first day of the calendar.
    send_dates(0, 5'd1,  4'd1,  12'd1900, 5'd1,  4'd1,  12'd1900);
    // The widest span in each direction.
    send_dates(0, 5'd1,  4'd1,  12'd1900, 5'd31, 4'd12, 12'd3000);
    send_dates(0, 5'd31, 4'd12, 12'd3000, 5'd1,  4'd1,  12'd1900);
    // Leap days: a century divisible by 400, plain centuries, a plain year.
    send_dates(0, 5'd29, 4'd2,  12'd2000, 5'd1,  4'd3,  12'd2000);
    send_dates(0, 5'd29, 4'd2,  12'd1900, 5'd1,  4'd1,  12'd2000);
    send_dates(0, 5'd1,  4'd1,  12'd2000, 5'd29, 4'd2,  12'd2100);
    send_dates(0, 5'd29, 4'd2,  12'd2004, 5'd28, 4'd2,  12'd2005);
    send_dates(0, 5'd30, 4'd9,  12'd2400, 5'd29, 4'd2,  12'd2400);
    // Day zero, and the 31st of a 30-day month.
    send_dates(0, 5'd0,  4'd1,  12'd2000, 5'd1,  4'd1,  12'd2000);
    send_dates(0, 5'd1,  4'd1,  12'd2000, 5'd31, 4'd4,  12'd2000);
    // Month codes that mean nothing.
    send_dates(0, 5'd1,  4'd0,  12'd2000, 5'd1,  4'd1,  12'd2000);
    send_dates(0, 5'd1,  4'd1,  12'd2000, 5'd1,  4'd13, 12'd2000);
    // All fields at their largest, then all at zero.
    send_dates(0, 5'd31, 4'd15, 12'd4095, 5'd31, 4'd15, 12'd4095);
    send_dates(0, 5'd0,  4'd0,  12'd0,    5'd0,  4'd0,  12'd0);
    // Years just outside the range on either side.
    send_dates(0, 5'd31, 4'd12, 12'd1899, 5'd1,  4'd1,  12'd1900);
    send_dates(0, 5'd1,  4'd1,  12'd3000, 5'd1,  4'd1,  12'd3001);
    // Ordinary spans: same date, within a year, across a year end, a long one.
    send_dates(0, 5'd15, 4'd6,  12'd2024, 5'd15, 4'd6,  12'd2024);
    send_dates(0, 5'd31, 4'd1,  12'd2023, 5'd30, 4'd11, 12'd2023);
    send_dates(0, 5'd28, 4'd2,  12'd2023, 5'd1,  4'd3,  12'd2023);
    send_dates(0, 5'd31, 4'd12, 12'd1999, 5'd1,  4'd1,  12'd2000);
    send_dates(0, 5'd1,  4'd1,  12'd3000, 5'd31, 4'd12, 12'd3000);
    send_dates(0, 5'd31, 4'd7,  12'd1950, 5'd4,  4'd7,  12'd2776);

    // Let the pipeline empty completely before the random part.
    hold_until_drained();

    // Random requests in bursts. Most carry two well-formed dates, some have a
    // field pushed out of range on one or both sides, and a few are pure noise
    // over the full width of every field. One stretch in the middle sends
    // without any gaps so the input runs at full rate against the stalls.
    for (int n = 0; n < RandomRequests; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = (n >= 600 && n < 800) ? 0 : $urandom_range(1, 8);
      end else begin
        gap = 0;
      end
      burst_left--;

      if (n == RandomRequests / 2) hold_until_drained();

      pick_date(fd, fm, fy);
      pick_date(td, tm, ty);
      kind = $urandom_range(0, 99);
      if (kind >= 94) begin
        noise = {$urandom, $urandom};
        {fd, fm, fy, td, tm, ty} = noise[41:0];
      end else if (kind >= 90) begin
        break_date(fd, fm, fy);
        break_date(td, tm, ty);
      end else if (kind >= 85) begin
        break_date(td, tm, ty);
      end else if (kind >= 80) begin
        break_date(fd, fm, fy);
      end
      send_dates(gap, fd, fm, fy, td, tm, ty);
    end
    in_valid <= 1'b0;

    // Wait for the last results, then DrainCycles more cycles to catch strays.
    while (pending_count != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/gdd_pkg.sv
design/gdd_lane.sv
design/gdd_merge.sv
design/gregorian_date_difference_top.sv
verif/gdd_span_checker.sv
verif/tb_gregorian_date_difference_top.sv
